// ===== rtl/core/pcm8_pkg.sv =====
// ----------------------------------------------------------------------------
// pcm8_pkg
// Shared types and constants of the eight-channel PCM sound generator.
// ----------------------------------------------------------------------------
package pcm8_pkg;

   localparam int DEF_NUM_CHANNELS  = 8;
   localparam int DEF_RAM_ADDR_BITS = 16;

   localparam int FUNC_W   = 2;
   localparam int ADDR_W   = 12;
   localparam int DATA_W   = 8;
   localparam int POS_W    = 27;
   localparam int FRAC_W   = 11;
   localparam int CHOUT_W  = 16;
   localparam int MIX_W    = 18;
   localparam int VOL_W    = 12;
   localparam int PROD_W   = 21;
   localparam int SHIFT    = 5;
   localparam int CLR_BITS = 6;

   localparam logic [DATA_W-1:0] END_MARK = 8'hFF;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_REG  = 2'd0,
      FUNC_MEM  = 2'd1,
      FUNC_TICK = 2'd2,
      FUNC_NONE = 2'd3
   } func_type;

   typedef enum logic [3:0] {
      REG_ENV   = 4'd0,
      REG_PAN   = 4'd1,
      REG_STEPL = 4'd2,
      REG_STEPH = 4'd3,
      REG_LOOPL = 4'd4,
      REG_LOOPH = 4'd5,
      REG_START = 4'd6,
      REG_CTRL  = 4'd7,
      REG_ENA   = 4'd8
   } reg_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_REG_RD,
      ST_REG_WR,
      ST_TK_RD,
      ST_TK_POS,
      ST_TK_SMP,
      ST_TK_LOOP,
      ST_TK_MUL,
      ST_TK_WB,
      ST_TK_OUT
   } state_type;

   typedef struct packed {
      logic        [POS_W-1:0]   pos;
      logic signed [CHOUT_W-1:0] out_l;
      logic signed [CHOUT_W-1:0] out_r;
   } chan_word_type;

endpackage

// ===== rtl/core/pcm8_if.sv =====
// ----------------------------------------------------------------------------
// pcm8_req_if / pcm8_rsp_if
// Valid/ready channels carrying requests and mixed stereo samples.
// ----------------------------------------------------------------------------
interface pcm8_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [11:0] address;
   logic [7:0]  data;
   modport source (output valid, func, address, data, input ready);
   modport sink   (input valid, func, address, data, output ready);
endinterface

interface pcm8_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [17:0] left_sample;
   logic signed [17:0] right_sample;
   modport source (output valid, left_sample, right_sample, input ready);
   modport sink   (input valid, left_sample, right_sample, output ready);
endinterface

// ===== rtl/core/eight_channel_pcm_sound_generator.sv =====
// ----------------------------------------------------------------------------
// eight_channel_pcm_sound_generator
// Eight-channel wavetable PCM generator with stereo mix output.
// ----------------------------------------------------------------------------
// After reset the block clears its sample RAM, one byte a cycle, before
// taking the first request. Register and memory writes complete in the
// idle state; a start-byte write to a disabled channel passes the read and
// write-back states once, an enable write once per channel, since each
// channel's entry is read and a disabled one's position is reset to its
// start byte. A tick walks the channels one after another through the
// channel memory and sample RAM read port: the read, position and write-back
// states for an idle channel, plus sample and multiply for a playing one
// and the loop state at an end marker; then the output state. The mixed
// sample waits in an output register while further requests are taken.
module eight_channel_pcm_sound_generator #(
   parameter int NUM_CHANNELS  = pcm8_pkg::DEF_NUM_CHANNELS,
   parameter int RAM_ADDR_BITS = pcm8_pkg::DEF_RAM_ADDR_BITS
) (
   input  logic      clock,
   input  logic      reset,
   pcm8_req_if.sink  req_chan,
   pcm8_rsp_if.source rsp_chan
);
   import pcm8_pkg::*;

   localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int RA_W     = RAM_ADDR_BITS;

   state_type state_ff, state_in;

   logic [DATA_W-1:0]  env_ff   [NUM_CHANNELS];
   logic [DATA_W-1:0]  pan_ff   [NUM_CHANNELS];
   logic [15:0]        step_ff  [NUM_CHANNELS];
   logic [15:0]        loop_ff  [NUM_CHANNELS];
   logic [DATA_W-1:0]  start_ff [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] ena_ff;
   logic               chip_on_ff;
   logic [2:0]         cbank_ff;
   logic [3:0]         mbank_ff;

   logic [RA_W-1:0]    clr_ff, clr_in;
   logic [CH_IDX_W-1:0] ch_ff, ch_in;
   logic               single_ff, single_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic signed [CHOUT_W-1:0] outl_ff, outl_in, outr_ff, outr_in;
   logic [VOL_W-1:0]   voll_ff, voll_in, volr_ff, volr_in;
   logic [DATA_W-1:0]  smp_ff, smp_in;
   logic signed [PROD_W-1:0] prodl_ff, prodl_in, prodr_ff, prodr_in;
   logic               upd_ff, upd_in;
   logic signed [MIX_W-1:0] suml_ff, suml_in, sumr_ff, sumr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [MIX_W-1:0] rspl_ff, rspl_in, rspr_ff, rspr_in;

   logic               ram_we;
   logic [RA_W-1:0]    ram_waddr, ram_raddr;
   logic [7:0]         ram_wdata, ram_rdata;
   logic               cm_we;
   logic [CH_IDX_W-1:0] cm_waddr, cm_raddr;
   chan_word_type      cm_wdata, cm_rdata;

   logic               accept;
   logic               bank_ok;
   logic [CH_IDX_W-1:0] bank_idx;
   logic               last_ch;
   logic signed [DATA_W-1:0]  sval;
   logic signed [CHOUT_W-1:0] newl, newr;

   pcm8_sample_ram #(.RAM_ADDR_BITS(RAM_ADDR_BITS)) u_sample_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   pcm8_chan_ram #(.NUM_CHANNELS(NUM_CHANNELS), .CH_IDX_W(CH_IDX_W)) u_chan_ram (
      .clock (clock),
      .reset (reset),
      .we    (cm_we),
      .waddr (cm_waddr),
      .wdata (cm_wdata),
      .raddr (cm_raddr),
      .rdata (cm_rdata)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept   = req_chan.valid && req_chan.ready;
   assign bank_ok  = (32'(cbank_ff) < NUM_CHANNELS);
   assign bank_idx = cbank_ff[CH_IDX_W-1:0];
   assign last_ch  = (32'(ch_ff) == NUM_CHANNELS - 1);

   // Sign-magnitude sample: bit 7 set means positive.
   assign sval = smp_ff[7] ? $signed({1'b0, smp_ff[6:0]})
                           : -$signed({1'b0, smp_ff[6:0]});
   assign newl = prodl_ff[PROD_W-1:SHIFT];
   assign newr = prodr_ff[PROD_W-1:SHIFT];

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.left_sample  = rspl_ff;
   assign rsp_chan.right_sample = rspr_ff;

   // Channel registers written directly by register requests.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            env_ff[i]   <= '0;
            pan_ff[i]   <= '0;
            step_ff[i]  <= '0;
            loop_ff[i]  <= '0;
            start_ff[i] <= '0;
         end
         ena_ff     <= '0;
         chip_on_ff <= 1'b0;
         cbank_ff   <= '0;
         mbank_ff   <= '0;
      end else if (accept && req_chan.func == FUNC_REG) begin
         if (req_chan.address == 12'(REG_CTRL)) begin
            chip_on_ff <= req_chan.data[7];
            if (req_chan.data[6]) begin
               cbank_ff <= req_chan.data[2:0];
            end else begin
               mbank_ff <= req_chan.data[3:0];
            end
         end else if (req_chan.address == 12'(REG_ENA)) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
               ena_ff[i] <= ~req_chan.data[i];
            end
         end else if (bank_ok) begin
            priority case (req_chan.address)
               12'(REG_ENV):   env_ff[bank_idx]        <= req_chan.data;
               12'(REG_PAN):   pan_ff[bank_idx]        <= req_chan.data;
               12'(REG_STEPL): step_ff[bank_idx][7:0]  <= req_chan.data;
               12'(REG_STEPH): step_ff[bank_idx][15:8] <= req_chan.data;
               12'(REG_LOOPL): loop_ff[bank_idx][7:0]  <= req_chan.data;
               12'(REG_LOOPH): loop_ff[bank_idx][15:8] <= req_chan.data;
               12'(REG_START): start_ff[bank_idx]      <= req_chan.data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         ch_ff        <= '0;
         single_ff    <= 1'b0;
         upd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         ch_ff        <= ch_in;
         single_ff    <= single_in;
         upd_ff       <= upd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      outl_ff  <= outl_in;
      outr_ff  <= outr_in;
      voll_ff  <= voll_in;
      volr_ff  <= volr_in;
      smp_ff   <= smp_in;
      prodl_ff <= prodl_in;
      prodr_ff <= prodr_in;
      suml_ff  <= suml_in;
      sumr_ff  <= sumr_in;
      rspl_ff  <= rspl_in;
      rspr_ff  <= rspr_in;
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      ch_in        = ch_ff;
      single_in    = single_ff;
      upd_in       = upd_ff;
      pos_in       = pos_ff;
      outl_in      = outl_ff;
      outr_in      = outr_ff;
      voll_in      = voll_ff;
      volr_in      = volr_ff;
      smp_in       = smp_ff;
      prodl_in     = prodl_ff;
      prodr_in     = prodr_ff;
      suml_in      = suml_ff;
      sumr_in      = sumr_ff;
      rspl_in      = rspl_ff;
      rspr_in      = rspr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      ram_we       = 1'b0;
      ram_waddr    = RA_W'({mbank_ff, req_chan.address});
      ram_wdata    = req_chan.data;
      ram_raddr    = cm_rdata.pos[FRAC_W +: RA_W];
      cm_we        = 1'b0;
      cm_waddr     = ch_ff;
      cm_wdata     = cm_rdata;
      cm_raddr     = ch_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               priority case (req_chan.func)
                  FUNC_REG: begin
                     if (req_chan.address == 12'(REG_ENA)) begin
                        ch_in     = '0;
                        single_in = 1'b0;
                        state_in  = ST_REG_RD;
                     end else if (req_chan.address == 12'(REG_START) && bank_ok
                                  && !ena_ff[bank_idx]) begin
                        ch_in     = bank_idx;
                        single_in = 1'b1;
                        state_in  = ST_REG_RD;
                     end
                  end
                  FUNC_MEM: ram_we = 1'b1;
                  FUNC_TICK: begin
                     ch_in    = '0;
                     suml_in  = '0;
                     sumr_in  = '0;
                     state_in = ST_TK_RD;
                  end
                  default: ;
               endcase
            end
         end
         ST_REG_RD: state_in = ST_REG_WR;
         ST_REG_WR: begin
            // Disabled channels restart from their start byte.
            if (!ena_ff[ch_ff]) begin
               cm_we        = 1'b1;
               cm_wdata.pos = {start_ff[ch_ff], 19'b0};
            end
            ch_in = ch_ff + 1'b1;
            if (single_ff || last_ch) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_REG_RD;
            end
         end
         ST_TK_RD: begin
            voll_in  = VOL_W'(pan_ff[ch_ff][3:0] * env_ff[ch_ff]);
            volr_in  = VOL_W'(pan_ff[ch_ff][7:4] * env_ff[ch_ff]);
            state_in = ST_TK_POS;
         end
         ST_TK_POS: begin
            pos_in  = cm_rdata.pos;
            outl_in = cm_rdata.out_l;
            outr_in = cm_rdata.out_r;
            upd_in  = 1'b0;
            if (chip_on_ff && ena_ff[ch_ff]) begin
               state_in = ST_TK_SMP;
            end else begin
               state_in = ST_TK_WB;
            end
         end
         ST_TK_SMP: begin
            if (ram_rdata == END_MARK) begin
               pos_in    = {loop_ff[ch_ff], 11'b0};
               ram_raddr = RA_W'(loop_ff[ch_ff]);
               state_in  = ST_TK_LOOP;
            end else begin
               smp_in   = ram_rdata;
               state_in = ST_TK_MUL;
            end
         end
         ST_TK_LOOP: begin
            // A second end marker keeps the outputs, but the channel stays
            // parked at its loop address.
            if (ram_rdata == END_MARK) begin
               state_in = ST_TK_WB;
            end else begin
               smp_in   = ram_rdata;
               state_in = ST_TK_MUL;
            end
         end
         ST_TK_MUL: begin
            prodl_in = PROD_W'(sval * $signed({1'b0, voll_ff}));
            prodr_in = PROD_W'(sval * $signed({1'b0, volr_ff}));
            pos_in   = pos_ff + POS_W'(step_ff[ch_ff]);
            upd_in   = 1'b1;
            state_in = ST_TK_WB;
         end
         ST_TK_WB: begin
            cm_we        = 1'b1;
            cm_wdata.pos = pos_ff;
            if (upd_ff) begin
               cm_wdata.out_l = newl;
               cm_wdata.out_r = newr;
               suml_in = suml_ff + MIX_W'(newl);
               sumr_in = sumr_ff + MIX_W'(newr);
            end else begin
               cm_wdata.out_l = outl_ff;
               cm_wdata.out_r = outr_ff;
               suml_in = suml_ff + MIX_W'(outl_ff);
               sumr_in = sumr_ff + MIX_W'(outr_ff);
            end
            ch_in = ch_ff + 1'b1;
            if (last_ch) begin
               state_in = ST_TK_OUT;
            end else begin
               state_in = ST_TK_RD;
            end
         end
         ST_TK_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rspl_in      = {suml_ff[MIX_W-1:CLR_BITS], {CLR_BITS{1'b0}}};
               rspr_in      = {sumr_ff[MIX_W-1:CLR_BITS], {CLR_BITS{1'b0}}};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

`ifndef NO_ASSERTIONS
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.func == FUNC_TICK) |=> !req_chan.ready)
      else $error("request taken right after a tick");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_TK_OUT))
      else $error("result raised outside the output state");

   a_ch_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TK_WB) |-> (32'(ch_ff) < NUM_CHANNELS))
      else $error("channel index out of range");
`endif
endmodule

// ===== rtl/core/pcm8_sample_ram.sv =====
// ----------------------------------------------------------------------------
// pcm8_sample_ram
// Byte-wide sample memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pcm8_sample_ram #(
   parameter int RAM_ADDR_BITS = pcm8_pkg::DEF_RAM_ADDR_BITS
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [RAM_ADDR_BITS-1:0] waddr,
   input  logic [7:0]               wdata,
   input  logic [RAM_ADDR_BITS-1:0] raddr,
   output logic [7:0]               rdata
);
   logic [7:0] mem [2**RAM_ADDR_BITS];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

// ===== rtl/core/pcm8_chan_ram.sv =====
// ----------------------------------------------------------------------------
// pcm8_chan_ram
// Per-channel position and output memory with reset-cleared valid bits.
// ----------------------------------------------------------------------------
module pcm8_chan_ram #(
   parameter int NUM_CHANNELS = pcm8_pkg::DEF_NUM_CHANNELS,
   parameter int CH_IDX_W     = 3
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    we,
   input  logic [CH_IDX_W-1:0]     waddr,
   input  pcm8_pkg::chan_word_type wdata,
   input  logic [CH_IDX_W-1:0]     raddr,
   output pcm8_pkg::chan_word_type rdata
);
   import pcm8_pkg::*;

   chan_word_type           mem [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] valid_ff;
   chan_word_type           rd_ff;
   logic                    rd_valid_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (we) begin
            valid_ff[waddr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[raddr];
      end
   end

   // An entry never written since reset reads as all zero.
   assign rdata = rd_valid_ff ? rd_ff : '0;
endmodule

// ===== tb/eight_channel_pcm_sound_generator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eight_channel_pcm_sound_generator_test
// Drives register writes, sample memory writes, ticks and unused function codes into the PCM
// generator and checks every mixed stereo sample against a built-in model.
// ----------------------------------------------------------------------------
module eight_channel_pcm_sound_generator_test;
   import pcm8_pkg::*;

   class pcm_mix_scoreboard;
      logic [7:0]  ram [65536];
      logic [7:0]  envelope [8];
      logic [7:0]  pan [8];
      logic [15:0] step [8];
      logic [15:0] loop_addr [8];
      logic [7:0]  start_val [8];
      logic [26:0] position [8];
      bit          enabled [8];
      int          out_left [8];
      int          out_right [8];
      bit          chip_on;
      logic [2:0]  channel_bank;
      logic [3:0]  memory_bank;
      logic [17:0] mix_left_q [$];
      logic [17:0] mix_right_q [$];
      int          mismatches;
      int          ticks;

      function new();
         foreach (ram[i]) ram[i] = 8'h00;
         for (int i = 0; i < 8; i++) begin
            envelope[i] = 0; pan[i] = 0; step[i] = 0; loop_addr[i] = 0;
            start_val[i] = 0; position[i] = 0; enabled[i] = 0;
            out_left[i] = 0; out_right[i] = 0;
         end
         chip_on = 0; channel_bank = 0; memory_bank = 0;
         mismatches = 0; ticks = 0;
      endfunction

      function int pending();
         return mix_left_q.size();
      endfunction

      // Rounds toward minus infinity, as an arithmetic shift of the product would.
      function int scale(int smp, int vol);
         int p;
         p = smp * vol;
         if (p >= 0) return p >>> 5;
         return -((-p + 31) >>> 5);
      endfunction

      function void write_reg(logic [11:0] a, logic [7:0] d);
         int c;
         c = channel_bank;
         if (a == 12'(REG_CTRL)) begin
            chip_on = d[7];
            if (d[6]) channel_bank = d[2:0];
            else memory_bank = d[3:0];
         end else if (a == 12'(REG_ENA)) begin
            for (int i = 0; i < 8; i++) begin
               enabled[i] = !d[i];
               if (!enabled[i]) position[i] = {start_val[i], 19'd0};
            end
         end else if (a <= 12'(REG_START)) begin
            case (a[3:0])
               REG_ENV: envelope[c] = d;
               REG_PAN: pan[c] = d;
               REG_STEPL: step[c][7:0] = d;
               REG_STEPH: step[c][15:8] = d;
               REG_LOOPL: loop_addr[c][7:0] = d;
               REG_LOOPH: loop_addr[c][15:8] = d;
               default: begin
                  start_val[c] = d;
                  if (!enabled[c]) position[c] = {d, 19'd0};
               end
            endcase
         end
      endfunction

      function void advance();
         logic [7:0] s;
         int smp, lv, rv;
         for (int i = 0; i < 8; i++) begin
            if (!enabled[i]) continue;
            lv = int'(pan[i][3:0]) * int'(envelope[i]);
            rv = int'(pan[i][7:4]) * int'(envelope[i]);
            s = ram[position[i][26:11]];
            if (s == END_MARK) begin
               position[i] = {loop_addr[i], 11'd0};
               s = ram[position[i][26:11]];
               if (s == END_MARK) continue;
            end
            position[i] = position[i] + 27'(step[i]);
            smp = int'(s[6:0]);
            if (!s[7]) smp = -smp;
            out_left[i] = scale(smp, lv);
            out_right[i] = scale(smp, rv);
         end
      endfunction

      function void note_request(func_type f, logic [11:0] a, logic [7:0] d);
         int sl, sr;
         case (f)
            FUNC_REG: write_reg(a, d);
            FUNC_MEM: ram[{memory_bank, a}] = d;
            FUNC_TICK: begin
               if (chip_on) advance();
               sl = 0; sr = 0;
               for (int i = 0; i < 8; i++) begin
                  sl += out_left[i];
                  sr += out_right[i];
               end
               mix_left_q = {mix_left_q, 18'(sl) & ~18'h3F};
               mix_right_q = {mix_right_q, 18'(sr) & ~18'h3F};
               ticks++;
            end
            default: ;
         endcase
      endfunction

      function void check_mix(logic [17:0] l, logic [17:0] r);
         logic [17:0] el, er;
         if (mix_left_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected sample: left %h right %h", l, r);
            return;
         end
         el = mix_left_q.pop_front();
         er = mix_right_q.pop_front();
         if (l !== el || r !== er) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Sample mismatch: left %h (expected %h), right %h (expected %h)",
                        l, el, r, er);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   recv_idle_pct;
   int   sent;
   pcm_mix_scoreboard mix_sb;

   pcm8_req_if req_chan();
   pcm8_rsp_if rsp_chan();

   eight_channel_pcm_sound_generator i_dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   initial begin
      #8ms;
      $display("Mismatches found");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         mix_sb.check_mix(rsp_chan.left_sample, rsp_chan.right_sample);
      rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic send(func_type f, logic [11:0] a, logic [7:0] d);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.func <= f;
      req_chan.address <= a;
      req_chan.data <= d;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      mix_sb.note_request(f, a, d);
      sent++;
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (mix_sb.pending() != 0) @(posedge clock);
   endtask

   // Loads a short sample with an end marker, points one channel at it and plays it.
   task automatic play_voice();
      logic [2:0]  c;
      logic [7:0]  sb;
      logic [11:0] base;
      int          len, lp;
      c = 3'($urandom_range(7));
      sb = 8'($urandom_range(255));
      base = {sb[3:0], 8'h00};
      len = $urandom_range(4, 20);
      lp = $urandom_range(0, len - 1);
      send(FUNC_REG, 12'(REG_CTRL), {2'b11, 3'b000, c});
      send(FUNC_REG, 12'(REG_CTRL), {4'h8, sb[7:4]});
      for (int i = 0; i < len; i++)
         send(FUNC_MEM, base + 12'(i), 8'($urandom_range(254)));
      send(FUNC_MEM, base + 12'(len), END_MARK);
      // Now and then the loop target is an end marker too, which freezes the voice.
      if ($urandom_range(7) == 0) send(FUNC_MEM, base + 12'(lp), END_MARK);
      send(FUNC_REG, 12'(REG_LOOPL), 8'(lp));
      send(FUNC_REG, 12'(REG_LOOPH), sb);
      if ($urandom_range(3) == 0) begin
         send(FUNC_REG, 12'(REG_STEPL), 8'($urandom_range(255)));
         send(FUNC_REG, 12'(REG_STEPH), 8'($urandom_range(255)));
      end else begin
         send(FUNC_REG, 12'(REG_STEPL), 8'($urandom_range(255)));
         send(FUNC_REG, 12'(REG_STEPH), 8'($urandom_range(1, 16)));
      end
      send(FUNC_REG, 12'(REG_ENV), 8'($urandom_range(255)));
      send(FUNC_REG, 12'(REG_PAN), 8'($urandom_range(255)));
      send(FUNC_REG, 12'(REG_ENA), 8'hFF);
      send(FUNC_REG, 12'(REG_START), sb);
      send(FUNC_REG, 12'(REG_ENA), 8'($urandom_range(255)) & ~(8'h01 << c));
      repeat ($urandom_range(5, 40)) send(FUNC_TICK, 12'($urandom_range(4095)),
                                         8'($urandom_range(255)));
   endtask

   task automatic send_noise();
      logic [11:0] a;
      logic [7:0]  d;
      int          k;
      a = 12'($urandom_range(4095));
      d = 8'($urandom_range(255));
      k = $urandom_range(99);
      if (k < 40) begin
         send(FUNC_TICK, a, d);
      end else if (k < 70) begin
         send(FUNC_MEM, a, d);
      end else if (k < 95) begin
         if ($urandom_range(3) != 0) a = 12'($urandom_range(8));
         // Keep the chip mostly running so that the voices keep moving.
         if (a == 12'(REG_CTRL) && $urandom_range(4) != 0) d[7] = 1'b1;
         send(FUNC_REG, a, d);
      end else begin
         send(FUNC_NONE, a, d);
      end
   endtask

   initial begin
      mix_sb = new();
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.func = FUNC_REG;
      req_chan.address = '0;
      req_chan.data = '0;
      rsp_chan.ready = 1'b0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      sent = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed corner cases: chip off, ignored codes, field extremes.
      send(FUNC_TICK, 12'h000, 8'h00);
      send(FUNC_NONE, 12'hFFF, 8'hFF);
      send(FUNC_REG, 12'd9, 8'hFF);
      send(FUNC_REG, 12'hFFF, 8'hFF);
      send(FUNC_MEM, 12'hFFF, 8'hFF);
      send(FUNC_MEM, 12'h000, 8'hFF);
      send(FUNC_MEM, 12'h001, 8'hFF);
      send(FUNC_REG, 12'(REG_CTRL), 8'h4F);
      send(FUNC_MEM, 12'h000, 8'h7F);
      send(FUNC_REG, 12'(REG_CTRL), 8'hC7);
      send(FUNC_REG, 12'(REG_ENV), 8'hFF);
      send(FUNC_REG, 12'(REG_PAN), 8'hFF);
      send(FUNC_REG, 12'(REG_STEPL), 8'hFF);
      send(FUNC_REG, 12'(REG_STEPH), 8'hFF);
      send(FUNC_REG, 12'(REG_LOOPL), 8'hFF);
      send(FUNC_REG, 12'(REG_LOOPH), 8'hFF);
      send(FUNC_REG, 12'(REG_START), 8'hFF);
      send(FUNC_REG, 12'(REG_ENA), 8'h00);
      send(FUNC_TICK, 12'hFFF, 8'hFF);
      send(FUNC_TICK, 12'h000, 8'h00);
      send(FUNC_REG, 12'(REG_CTRL), 8'h40);
      send(FUNC_TICK, 12'h555, 8'hAA);
      send(FUNC_REG, 12'(REG_CTRL), 8'h80);
      send(FUNC_TICK, 12'hAAA, 8'h55);
      send(FUNC_REG, 12'(REG_ENA), 8'hFF);
      drain();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 85 : 0;
         recv_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 21 : 0;
         while (sent < 25 + 360 * (phase + 1)) begin
            if ($urandom_range(99) < 15) play_voice();
            else send_noise();
         end
         drain();
      end

      repeat (100) @(posedge clock);
      $display("Sent %0d requests, including %0d ticks, under three idle patterns.",
               sent, mix_sb.ticks);
      if (mix_sb.mismatches == 0 && mix_sb.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
